FILE: design/flash_sector_stack_manager_defines.svh
// Assertion macros shared by the checker of the flash sector stack manager.
`ifndef FLASH_SECTOR_STACK_MANAGER_DEFINES_SVH
`define FLASH_SECTOR_STACK_MANAGER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define FSSM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define FSSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fssm_pkg.sv
// Types, constants and default parameters of the flash sector stack manager.
package fssm_pkg;

    localparam int unsigned SECTOR_BYTES_DEF = 4096;
    localparam int unsigned LAST_SECTOR_DEF  = 2047;
    localparam int unsigned SIZE_KB_DEF      = 8192;

    localparam int unsigned MAX_RESULTS = 40;
    localparam int unsigned MAX_OPS     = MAX_RESULTS - 1;
    localparam int unsigned OPS_W       = $clog2(MAX_RESULTS);
    localparam int unsigned KB_SHIFT    = 10;
    localparam int unsigned FREE_KB_MAX = 16383;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned OP_W   = 2;
    localparam int unsigned ADDR_W = 23;
    localparam int unsigned FREE_W = 14;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT,
        CMD_PUSH,
        CMD_PULL,
        CMD_DROP
    } cmd_t;

    typedef enum logic [OP_W-1:0] {
        OP_STATUS,
        OP_ERASE,
        OP_WRITE,
        OP_READ
    } fop_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_INIT,
        ACT_PUSH_ERASE,
        ACT_PUSH_WRITE,
        ACT_PUSH_COMMIT,
        ACT_PULL,
        ACT_DROP_STEP,
        ACT_DROP_READ,
        ACT_DROP_ERASE,
        ACT_DROP_WRITE,
        ACT_STATUS
    } act_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INIT,
        ST_PUSH,
        ST_PULL,
        ST_DROP_WALK,
        ST_DROP_CHK,
        ST_DROP_ER,
        ST_DROP_WR,
        ST_STATUS
    } state_t;

    typedef struct packed {
        cmd_t cmd;
        logic left_zero;
        logic sector_full;
        logic can_advance;
        logic pull_ok;
        logic walk_last;
        logic walk_under;
        logic drop_in_range;
        logic out_free;
    } dp_status_t;

endpackage

FILE: design/fssm_req_if.sv
// Command channel: valid, ready and one command word.
interface fssm_req_if;
    logic                         valid;
    logic                         ready;
    logic [fssm_pkg::CMD_W-1:0]   cmd;
    logic [fssm_pkg::CNT_W-1:0]   byte_count;
    logic [fssm_pkg::CNT_W-1:0]   displacement;

    modport source (output valid, output cmd, output byte_count, output displacement,
                    input ready);
    modport sink (input valid, input cmd, input byte_count, input displacement,
                  output ready);
endinterface

FILE: design/fssm_rsp_if.sv
// Result channel: valid, ready and one flash operation or status word.
interface fssm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fssm_pkg::OP_W-1:0]     op;
    logic [fssm_pkg::ADDR_W-1:0]   flash_address;
    logic [fssm_pkg::CNT_W-1:0]    length;
    logic [fssm_pkg::CNT_W-1:0]    buffer_offset;
    logic                          use_scratch;
    logic [fssm_pkg::CNT_W-1:0]    count_done;
    logic [fssm_pkg::FREE_W-1:0]   free_kb;
    logic                          last;

    modport source (output valid, output op, output flash_address, output length,
                    output buffer_offset, output use_scratch, output count_done,
                    output free_kb, output last, input ready);
    modport sink (input valid, input op, input flash_address, input length,
                  input buffer_offset, input use_scratch, input count_done,
                  input free_kb, input last, output ready);
endinterface

FILE: design/fssm_datapath.sv
// Datapath: stack pointer, working pointer for the current command and the result register.
module fssm_datapath #(
    parameter int unsigned SECTOR_BYTES = fssm_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned LAST_SECTOR  = fssm_pkg::LAST_SECTOR_DEF,
    parameter int unsigned SIZE_KB      = fssm_pkg::SIZE_KB_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fssm_pkg::act_t                act,
    input  logic [fssm_pkg::CMD_W-1:0]    cmd,
    input  logic [fssm_pkg::CNT_W-1:0]    byte_count,
    input  logic [fssm_pkg::CNT_W-1:0]    displacement,
    output fssm_pkg::dp_status_t          status,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [fssm_pkg::OP_W-1:0]     rsp_op,
    output logic [fssm_pkg::ADDR_W-1:0]   rsp_flash_address,
    output logic [fssm_pkg::CNT_W-1:0]    rsp_length,
    output logic [fssm_pkg::CNT_W-1:0]    rsp_buffer_offset,
    output logic                          rsp_use_scratch,
    output logic [fssm_pkg::CNT_W-1:0]    rsp_count_done,
    output logic [fssm_pkg::FREE_W-1:0]   rsp_free_kb,
    output logic                          rsp_last
);

    localparam int unsigned SW  = $clog2(LAST_SECTOR + 2);
    localparam int unsigned OW  = $clog2(SECTOR_BYTES + 1);
    localparam int unsigned PW  = SW + OW;
    localparam int unsigned NW  = fssm_pkg::CNT_W + 1;
    localparam int unsigned CW  = (PW > NW) ? PW : NW;
    localparam int unsigned UW  = PW - fssm_pkg::KB_SHIFT;
    localparam int unsigned KW  = (UW > NW) ? UW : NW;
    localparam int unsigned CTW = fssm_pkg::CNT_W;
    localparam int unsigned OPW = fssm_pkg::OPS_W;

    localparam logic [OW-1:0]  S_O    = OW'(SECTOR_BYTES);
    localparam logic [PW-1:0]  S_P    = PW'(SECTOR_BYTES);
    localparam logic [SW-1:0]  LAST_S = SW'(LAST_SECTOR);
    localparam logic [OPW-1:0] OPS_MX = OPW'(fssm_pkg::MAX_OPS);

    logic [SW-1:0]   sec_reg, sec_next;
    logic [OW-1:0]   off_reg, off_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [OPW-1:0]  ops_reg, ops_next;
    logic            valid_reg, valid_next;

    logic [SW-1:0]   ws_reg, ws_next;
    logic [OW-1:0]   wo_reg, wo_next;
    logic [PW-1:0]   wp_reg, wp_next;
    logic [PW-1:0]   base_reg, base_next;
    logic [CTW-1:0]  left_reg, left_next;
    logic [CTW-1:0]  done_reg, done_next;
    logic [CTW-1:0]  n_reg, n_next;
    logic [CTW-1:0]  disp_reg, disp_next;
    logic [CTW-1:0]  count_reg, count_next;
    fssm_pkg::cmd_t  cmd_reg, cmd_next;

    fssm_pkg::fop_t                op_reg, op_next;
    logic [fssm_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [CTW-1:0]                len_reg, len_next;
    logic [CTW-1:0]                boff_reg, boff_next;
    logic                          scr_reg, scr_next;
    logic [CTW-1:0]                cnt_reg, cnt_next;
    logic [fssm_pkg::FREE_W-1:0]   free_reg, free_next;
    logic                          last_reg, last_next;

    logic [OW-1:0]   room;
    logic [CTW-1:0]  len_push;
    logic [NW-1:0]   need;
    logic            pull_ok;
    logic [CW-1:0]   pull_addr;
    logic            walk_last;
    logic [OW-1:0]   wo_sub;
    logic [UW-1:0]   used;
    logic [KW-1:0]   free_full;
    logic [fssm_pkg::FREE_W-1:0] free_val;
    logic            op_allowed;
    logic            out_free;

    logic                        e_flash;
    logic                        e_status;
    fssm_pkg::fop_t              e_op;
    logic [PW-1:0]               e_addr;
    logic [CTW-1:0]              e_len;
    logic [CTW-1:0]              e_boff;
    logic                        e_scr;

    assign room      = S_O - wo_reg;
    assign len_push  = (NW'(left_reg) < NW'(room)) ? left_reg : CTW'(room);
    assign need      = NW'(n_reg) + NW'(disp_reg);
    assign pull_ok   = CW'(pos_reg) >= CW'(need);
    assign pull_addr = CW'(pos_reg) - CW'(need);
    assign walk_last = NW'(left_reg) <= NW'(wo_reg);
    assign wo_sub    = wo_reg - OW'(left_reg);
    assign used      = pos_reg[PW-1:fssm_pkg::KB_SHIFT];
    assign free_full = (KW'(SIZE_KB) > KW'(used)) ? (KW'(SIZE_KB) - KW'(used)) : '0;
    assign free_val  = (free_full > KW'(fssm_pkg::FREE_KB_MAX))
                       ? fssm_pkg::FREE_W'(fssm_pkg::FREE_KB_MAX)
                       : fssm_pkg::FREE_W'(free_full);
    assign op_allowed = ops_reg < OPS_MX;
    assign out_free   = !valid_reg || rsp_ready;

    always_comb
    begin
        sec_next   = sec_reg;
        off_next   = off_reg;
        pos_next   = pos_reg;
        ops_next   = ops_reg;
        ws_next    = ws_reg;
        wo_next    = wo_reg;
        wp_next    = wp_reg;
        base_next  = base_reg;
        left_next  = left_reg;
        done_next  = done_reg;
        n_next     = n_reg;
        disp_next  = disp_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        e_flash    = 1'b0;
        e_status   = 1'b0;
        e_op       = fssm_pkg::OP_STATUS;
        e_addr     = '0;
        e_len      = '0;
        e_boff     = '0;
        e_scr      = 1'b0;

        unique case (act)
            fssm_pkg::ACT_NONE:
            begin
            end
            fssm_pkg::ACT_LOAD:
            begin
                cmd_next   = fssm_pkg::cmd_t'(cmd);
                n_next     = byte_count;
                disp_next  = displacement;
                left_next  = byte_count;
                done_next  = '0;
                count_next = '0;
                ops_next   = '0;
                ws_next    = sec_reg;
                wo_next    = off_reg;
                wp_next    = pos_reg;
                base_next  = pos_reg - PW'(off_reg);
            end
            fssm_pkg::ACT_INIT:
            begin
                e_flash  = 1'b1;
                e_op     = fssm_pkg::OP_ERASE;
                sec_next = '0;
                off_next = '0;
                pos_next = '0;
            end
            fssm_pkg::ACT_PUSH_ERASE:
            begin
                e_flash = 1'b1;
                e_op    = fssm_pkg::OP_ERASE;
                e_addr  = wp_reg;
                ws_next = ws_reg + SW'(1);
                wo_next = '0;
            end
            fssm_pkg::ACT_PUSH_WRITE:
            begin
                e_flash   = 1'b1;
                e_op      = fssm_pkg::OP_WRITE;
                e_addr    = wp_reg;
                e_len     = len_push;
                e_boff    = done_reg;
                left_next = left_reg - len_push;
                wo_next   = wo_reg + OW'(len_push);
                wp_next   = wp_reg + PW'(len_push);
                done_next = done_reg + len_push;
            end
            fssm_pkg::ACT_PUSH_COMMIT:
            begin
                sec_next   = ws_reg;
                off_next   = wo_reg;
                pos_next   = wp_reg;
                count_next = done_reg;
            end
            fssm_pkg::ACT_PULL:
            begin
                e_flash    = 1'b1;
                e_op       = fssm_pkg::OP_READ;
                e_addr     = PW'(pull_addr);
                e_len      = n_reg;
                count_next = n_reg;
            end
            fssm_pkg::ACT_DROP_STEP:
            begin
                if (walk_last)
                begin
                    left_next = '0;
                    if (left_reg == '0 && wo_reg == S_O)
                    begin
                        ws_next   = ws_reg + SW'(1);
                        base_next = base_reg + S_P;
                        wo_next   = '0;
                    end
                    else
                    begin
                        wo_next = wo_sub;
                    end
                end
                else
                begin
                    left_next = left_reg - CTW'(wo_reg);
                    ws_next   = ws_reg - SW'(1);
                    wo_next   = S_O;
                    base_next = base_reg - S_P;
                end
            end
            fssm_pkg::ACT_DROP_READ:
            begin
                e_flash = 1'b1;
                e_op    = fssm_pkg::OP_READ;
                e_addr  = base_reg;
                e_len   = CTW'(wo_reg);
                e_scr   = 1'b1;
            end
            fssm_pkg::ACT_DROP_ERASE:
            begin
                e_flash = 1'b1;
                e_op    = fssm_pkg::OP_ERASE;
                e_addr  = base_reg;
            end
            fssm_pkg::ACT_DROP_WRITE:
            begin
                e_flash    = 1'b1;
                e_op       = fssm_pkg::OP_WRITE;
                e_addr     = base_reg;
                e_len      = CTW'(wo_reg);
                e_scr      = 1'b1;
                sec_next   = ws_reg;
                off_next   = wo_reg;
                pos_next   = base_reg + PW'(wo_reg);
                count_next = n_reg;
            end
            fssm_pkg::ACT_STATUS:
            begin
                e_status = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // The result register is loaded only when the controller has seen it free.
    always_comb
    begin
        valid_next = valid_reg && !rsp_ready;
        op_next    = op_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        boff_next  = boff_reg;
        scr_next   = scr_reg;
        cnt_next   = cnt_reg;
        free_next  = free_reg;
        last_next  = last_reg;
        if (e_flash && op_allowed)
        begin
            valid_next = 1'b1;
            op_next    = e_op;
            addr_next  = fssm_pkg::ADDR_W'(e_addr);
            len_next   = e_len;
            boff_next  = e_boff;
            scr_next   = e_scr;
            cnt_next   = '0;
            free_next  = '0;
            last_next  = 1'b0;
        end
        else if (e_status)
        begin
            valid_next = 1'b1;
            op_next    = fssm_pkg::OP_STATUS;
            addr_next  = '0;
            len_next   = '0;
            boff_next  = '0;
            scr_next   = 1'b0;
            cnt_next   = count_reg;
            free_next  = free_val;
            last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg   <= '0;
            off_reg   <= '0;
            pos_reg   <= '0;
            ops_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sec_reg   <= sec_next;
            off_reg   <= off_next;
            pos_reg   <= pos_next;
            ops_reg   <= (e_flash && op_allowed) ? ops_reg + OPW'(1) : ops_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ws_reg    <= ws_next;
        wo_reg    <= wo_next;
        wp_reg    <= wp_next;
        base_reg  <= base_next;
        left_reg  <= left_next;
        done_reg  <= done_next;
        n_reg     <= n_next;
        disp_reg  <= disp_next;
        count_reg <= count_next;
        cmd_reg   <= cmd_next;
        op_reg    <= op_next;
        addr_reg  <= addr_next;
        len_reg   <= len_next;
        boff_reg  <= boff_next;
        scr_reg   <= scr_next;
        cnt_reg   <= cnt_next;
        free_reg  <= free_next;
        last_reg  <= last_next;
    end

    assign status.cmd           = cmd_reg;
    assign status.left_zero     = left_reg == '0;
    assign status.sector_full   = wo_reg >= S_O;
    assign status.can_advance   = ws_reg < LAST_S;
    assign status.pull_ok       = pull_ok;
    assign status.walk_last     = walk_last;
    assign status.walk_under    = !walk_last && ws_reg == '0;
    assign status.drop_in_range = ws_reg <= LAST_S;
    assign status.out_free      = out_free;

    assign rsp_valid         = valid_reg;
    assign rsp_op            = op_reg;
    assign rsp_flash_address = addr_reg;
    assign rsp_length        = len_reg;
    assign rsp_buffer_offset = boff_reg;
    assign rsp_use_scratch   = scr_reg;
    assign rsp_count_done    = cnt_reg;
    assign rsp_free_kb       = free_reg;
    assign rsp_last          = last_reg;

endmodule

FILE: design/fssm_ctrl.sv
// Controller: sequences the flash operations and the status word of each command.
module fssm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  fssm_pkg::dp_status_t  status,
    output fssm_pkg::act_t        act
);

    fssm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fssm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        act        = fssm_pkg::ACT_NONE;
        req_ready  = 1'b0;
        unique case (state_reg)
            fssm_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    act        = fssm_pkg::ACT_LOAD;
                    state_next = fssm_pkg::ST_DECODE;
                end
            end
            fssm_pkg::ST_DECODE:
            begin
                unique case (status.cmd)
                    fssm_pkg::CMD_INIT: state_next = fssm_pkg::ST_INIT;
                    fssm_pkg::CMD_PUSH: state_next = fssm_pkg::ST_PUSH;
                    fssm_pkg::CMD_PULL: state_next = fssm_pkg::ST_PULL;
                    fssm_pkg::CMD_DROP: state_next = fssm_pkg::ST_DROP_WALK;
                    default:            state_next = fssm_pkg::ST_STATUS;
                endcase
            end
            fssm_pkg::ST_INIT:
            begin
                if (status.out_free)
                begin
                    act        = fssm_pkg::ACT_INIT;
                    state_next = fssm_pkg::ST_STATUS;
                end
            end
            fssm_pkg::ST_PUSH:
            begin
                priority if (status.left_zero)
                begin
                    act        = fssm_pkg::ACT_PUSH_COMMIT;
                    state_next = fssm_pkg::ST_STATUS;
                end
                else if (status.sector_full && !status.can_advance)
                begin
                    // The stack is full: the pointer stays where it was.
                    state_next = fssm_pkg::ST_STATUS;
                end
                else if (status.out_free)
                begin
                    act = status.sector_full ? fssm_pkg::ACT_PUSH_ERASE
                                             : fssm_pkg::ACT_PUSH_WRITE;
                end
            end
            fssm_pkg::ST_PULL:
            begin
                priority if (!status.pull_ok)
                begin
                    state_next = fssm_pkg::ST_STATUS;
                end
                else if (status.out_free)
                begin
                    act        = fssm_pkg::ACT_PULL;
                    state_next = fssm_pkg::ST_STATUS;
                end
            end
            fssm_pkg::ST_DROP_WALK:
            begin
                priority if (status.walk_under)
                begin
                    state_next = fssm_pkg::ST_STATUS;
                end
                else
                begin
                    act = fssm_pkg::ACT_DROP_STEP;
                    if (status.walk_last)
                    begin
                        state_next = fssm_pkg::ST_DROP_CHK;
                    end
                end
            end
            fssm_pkg::ST_DROP_CHK:
            begin
                priority if (!status.drop_in_range)
                begin
                    state_next = fssm_pkg::ST_STATUS;
                end
                else if (status.out_free)
                begin
                    act        = fssm_pkg::ACT_DROP_READ;
                    state_next = fssm_pkg::ST_DROP_ER;
                end
            end
            fssm_pkg::ST_DROP_ER:
            begin
                if (status.out_free)
                begin
                    act        = fssm_pkg::ACT_DROP_ERASE;
                    state_next = fssm_pkg::ST_DROP_WR;
                end
            end
            fssm_pkg::ST_DROP_WR:
            begin
                if (status.out_free)
                begin
                    act        = fssm_pkg::ACT_DROP_WRITE;
                    state_next = fssm_pkg::ST_STATUS;
                end
            end
            fssm_pkg::ST_STATUS:
            begin
                if (status.out_free)
                begin
                    act        = fssm_pkg::ACT_STATUS;
                    state_next = fssm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fssm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/flash_sector_stack_manager.sv
// Top level of the flash sector stack manager: controller, datapath and channel ports.
// The block takes one command word at a time and answers with one word per flash
// operation followed by a status word with last set. A word goes out only while the
// result register is free. A drop finds the new top by stepping back from the old top
// a sector at a time, about byte_count / SECTOR_BYTES sectors; a drop that underflows
// ends sooner. A new command is taken as soon as the status word sits in the result
// register, while that word still waits to be taken. Flash operations beyond the
// thirty-ninth of a command are not sent, but the controller still steps through them.
module flash_sector_stack_manager #(
    parameter int unsigned SECTOR_BYTES = fssm_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned LAST_SECTOR  = fssm_pkg::LAST_SECTOR_DEF,
    parameter int unsigned SIZE_KB      = fssm_pkg::SIZE_KB_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fssm_req_if.sink    req,
    fssm_rsp_if.source  rsp
);

    fssm_pkg::dp_status_t status;
    fssm_pkg::act_t       act;

    fssm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .act       (act)
    );

    fssm_datapath #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .LAST_SECTOR  (LAST_SECTOR),
        .SIZE_KB      (SIZE_KB)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .act               (act),
        .cmd               (req.cmd),
        .byte_count        (req.byte_count),
        .displacement      (req.displacement),
        .status            (status),
        .rsp_valid         (rsp.valid),
        .rsp_ready         (rsp.ready),
        .rsp_op            (rsp.op),
        .rsp_flash_address (rsp.flash_address),
        .rsp_length        (rsp.length),
        .rsp_buffer_offset (rsp.buffer_offset),
        .rsp_use_scratch   (rsp.use_scratch),
        .rsp_count_done    (rsp.count_done),
        .rsp_free_kb       (rsp.free_kb),
        .rsp_last          (rsp.last)
    );

endmodule

FILE: design/fssm_checker.sv
// Port checker of the flash sector stack manager and its bind to the top level.
`include "flash_sector_stack_manager_defines.svh"

module fssm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [fssm_pkg::OP_W-1:0]     rsp_op,
    input logic [fssm_pkg::ADDR_W-1:0]   rsp_flash_address,
    input logic [fssm_pkg::CNT_W-1:0]    rsp_length,
    input logic [fssm_pkg::CNT_W-1:0]    rsp_buffer_offset,
    input logic                          rsp_use_scratch,
    input logic [fssm_pkg::CNT_W-1:0]    rsp_count_done,
    input logic [fssm_pkg::FREE_W-1:0]   rsp_free_kb,
    input logic                          rsp_last
);

    `FSSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_op, rsp_flash_address, rsp_length, rsp_buffer_offset, rsp_use_scratch, rsp_count_done, rsp_free_kb, rsp_last}), "stalled result word changed")
    `FSSM_ASSERT_SAME(a_status_clean, rsp_valid && rsp_last, rsp_op == fssm_pkg::OP_STATUS && rsp_flash_address == '0 && rsp_length == '0 && rsp_buffer_offset == '0 && !rsp_use_scratch, "status word carries flash fields")
    `FSSM_ASSERT_SAME(a_op_clean, rsp_valid && !rsp_last, rsp_op != fssm_pkg::OP_STATUS && rsp_count_done == '0 && rsp_free_kb == '0, "flash word carries status fields")
    `FSSM_ASSERT_SAME(a_erase_clean, rsp_valid && rsp_op == fssm_pkg::OP_ERASE, rsp_length == '0 && rsp_buffer_offset == '0 && !rsp_use_scratch, "erase word carries a length")
    `FSSM_ASSERT_NEXT(a_busy_after_cmd, req_valid && req_ready, !req_ready, "command taken while busy")

endmodule

bind flash_sector_stack_manager fssm_checker u_fssm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_op            (rsp.op),
    .rsp_flash_address (rsp.flash_address),
    .rsp_length        (rsp.length),
    .rsp_buffer_offset (rsp.buffer_offset),
    .rsp_use_scratch   (rsp.use_scratch),
    .rsp_count_done    (rsp.count_done),
    .rsp_free_kb       (rsp.free_kb),
    .rsp_last          (rsp.last)
);

FILE: verif/tb_flash_sector_stack_manager.sv
// Self-checking testbench of the flash sector stack manager: directed table, then random commands.
`timescale 1ns / 1ps

module tb_flash_sector_stack_manager;

    import fssm_pkg::*;

    localparam int unsigned SECTOR      = SECTOR_BYTES_DEF;
    localparam int unsigned LAST_SECTOR = LAST_SECTOR_DEF;
    localparam int unsigned CAPACITY_KB = SIZE_KB_DEF;
    localparam longint unsigned STACK_BYTES = 64'(LAST_SECTOR + 1) * SECTOR;
    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned WATCH_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES  = 60;

    typedef struct packed {
        fop_t        op;
        logic [22:0] addr;
        logic [15:0] len;
        logic [15:0] boff;
        logic        scratch;
        logic [15:0] done;
        logic [13:0] spare_kb;
        logic        is_last;
    } flash_word_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] count;
        logic [15:0] disp;
        logic        pinned;
        logic [15:0] pin_done;
        logic [13:0] pin_spare;
    } step_row_t;

    typedef enum {GEN_CLIMB, GEN_SUMMIT, GEN_MIXED} gen_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    fssm_req_if req_ch();
    fssm_rsp_if rsp_ch();

    flash_sector_stack_manager dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    flash_word_t due_words[$];
    flash_word_t got_w;
    flash_word_t exp_w;
    step_row_t   script[$];
    int unsigned stack_sector = 0;
    int unsigned stack_offset = 0;
    int unsigned ops_in_cmd;
    int unsigned fault_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_pct = 0;
    int unsigned idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned summit_left = 0;
    gen_mode_t   gen_mode = GEN_CLIMB;

    function automatic step_row_t row(input cmd_t c, input int unsigned n, input int unsigned d,
                                      input bit pinned, input int unsigned pdone,
                                      input int unsigned pspare);
        step_row_t r;
        r.cmd       = c;
        r.count     = n[15:0];
        r.disp      = d[15:0];
        r.pinned    = pinned;
        r.pin_done  = pdone[15:0];
        r.pin_spare = pspare[13:0];
        return r;
    endfunction

    function automatic void queue_op(input fop_t op, input longint unsigned addr,
                                     input int unsigned len, input int unsigned boff,
                                     input bit scratch);
        flash_word_t w;
        if (ops_in_cmd >= MAX_OPS)
            return;
        w = '0;
        w.op      = op;
        w.addr    = addr[22:0];
        w.len     = len[15:0];
        w.boff    = boff[15:0];
        w.scratch = scratch;
        due_words.push_back(w);
        ops_in_cmd++;
    endfunction

    function automatic void plan_flash_ops(input cmd_t c, input int unsigned n,
                                           input int unsigned disp);
        longint unsigned pos, need, new_top, base, used, spare;
        int unsigned sec, off, left, done, room, len, count;
        bit fail;
        flash_word_t w;
        pos = 64'(stack_sector) * SECTOR + stack_offset;
        count = 0;
        ops_in_cmd = 0;
        case (c)
            CMD_INIT:
            begin
                queue_op(OP_ERASE, 0, 0, 0, 1'b0);
                stack_sector = 0;
                stack_offset = 0;
            end
            CMD_PUSH:
            begin
                sec = stack_sector;
                off = stack_offset;
                left = n;
                done = 0;
                fail = 1'b0;
                while (left > 0 && !fail)
                begin
                    if (off >= SECTOR)
                    begin
                        if (sec < LAST_SECTOR)
                        begin
                            sec++;
                            off = 0;
                            queue_op(OP_ERASE, 64'(sec) * SECTOR, 0, 0, 1'b0);
                        end
                        else
                            fail = 1'b1;
                    end
                    if (!fail)
                    begin
                        room = SECTOR - off;
                        len = (left < room) ? left : room;
                        queue_op(OP_WRITE, 64'(sec) * SECTOR + off, len, done, 1'b0);
                        left -= len;
                        off += len;
                        done += len;
                    end
                end
                if (!fail)
                begin
                    stack_sector = sec;
                    stack_offset = off;
                    count = done;
                end
            end
            CMD_PULL:
            begin
                need = 64'(n) + disp;
                if (pos >= need)
                begin
                    queue_op(OP_READ, pos - need, n, 0, 1'b0);
                    count = n;
                end
            end
            CMD_DROP:
            begin
                if (pos >= n)
                begin
                    new_top = pos - n;
                    if (new_top / SECTOR <= LAST_SECTOR)
                    begin
                        base = (new_top / SECTOR) * SECTOR;
                        queue_op(OP_READ, base, 32'(new_top % SECTOR), 0, 1'b1);
                        queue_op(OP_ERASE, base, 0, 0, 1'b0);
                        queue_op(OP_WRITE, base, 32'(new_top % SECTOR), 0, 1'b1);
                        stack_sector = 32'(new_top / SECTOR);
                        stack_offset = 32'(new_top % SECTOR);
                        count = n;
                    end
                end
            end
        endcase
        used = (64'(stack_sector) * SECTOR + stack_offset) / 1024;
        spare = (CAPACITY_KB > used) ? CAPACITY_KB - used : 0;
        if (spare > FREE_KB_MAX)
            spare = FREE_KB_MAX;
        w = '0;
        w.op       = OP_STATUS;
        w.done     = count[15:0];
        w.spare_kb = spare[13:0];
        w.is_last  = 1'b1;
        due_words.push_back(w);
    endfunction

    function automatic void pick_command(output cmd_t c, output int unsigned n,
                                         output int unsigned disp);
        longint unsigned room;
        int unsigned r;
        room = STACK_BYTES - (64'(stack_sector) * SECTOR + stack_offset);
        r = $urandom_range(0, 99);
        c = CMD_PULL;
        n = $urandom_range(0, 65535);
        disp = $urandom_range(0, 65535);
        if (gen_mode == GEN_CLIMB && room < 65536)
        begin
            gen_mode = GEN_SUMMIT;
            summit_left = 40;
        end
        case (gen_mode)
            GEN_CLIMB:
            begin
                if (r < 85)
                begin
                    c = CMD_PUSH;
                    n = $urandom_range(49152, 65535);
                end
                else if (r >= 92)
                begin
                    c = CMD_DROP;
                    n = $urandom_range(0, 4096);
                end
            end
            GEN_SUMMIT:
            begin
                if (r < 25)
                begin
                    c = CMD_PUSH;
                    n = (room > 65535) ? 65535 : 32'(room);
                end
                else if (r < 45)
                begin
                    c = CMD_PUSH;
                    n = (room >= 65535) ? 65535 : $urandom_range(32'(room) + 1, 65535);
                end
                else if (r < 60)
                begin
                    c = CMD_DROP;
                    n = 0;
                end
                else if (r < 80)
                begin
                    c = CMD_DROP;
                    n = $urandom_range(0, 8192);
                end
                summit_left--;
                if (summit_left == 0)
                    gen_mode = GEN_MIXED;
            end
            default:
            begin
                if (r < 5)
                    c = CMD_INIT;
                else if (r < 40)
                begin
                    c = CMD_PUSH;
                    if ($urandom_range(0, 1) == 0)
                        n = $urandom_range(0, 8191);
                end
                else if (r >= 70)
                begin
                    c = CMD_DROP;
                    if ($urandom_range(0, 1) == 0)
                        n = $urandom_range(0, 8191);
                end
            end
        endcase
    endfunction

    task automatic offer_command(input cmd_t c, input int unsigned n, input int unsigned disp);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= c;
        req_ch.byte_count   <= n[15:0];
        req_ch.displacement <= disp[15:0];
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        plan_flash_ops(c, n, disp);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served < hold_requests)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_w.op       = fop_t'(rsp_ch.op);
            got_w.addr     = rsp_ch.flash_address;
            got_w.len      = rsp_ch.length;
            got_w.boff     = rsp_ch.buffer_offset;
            got_w.scratch  = rsp_ch.use_scratch;
            got_w.done     = rsp_ch.count_done;
            got_w.spare_kb = rsp_ch.free_kb;
            got_w.is_last  = rsp_ch.last;
            if (due_words.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("Unexpected word: op=%0d addr=%0h len=%0d done=%0d last=%0b",
                             got_w.op, got_w.addr, got_w.len, got_w.done, got_w.is_last);
            end
            else
            begin
                exp_w = due_words.pop_front();
                if (got_w !== exp_w)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"Word mismatch at %0t: expected op=%0d addr=%0h len=%0d ",
                                  "boff=%0d scratch=%0b done=%0d free=%0d last=%0b, got op=%0d ",
                                  "addr=%0h len=%0d boff=%0d scratch=%0b done=%0d free=%0d ",
                                  "last=%0b"}, $realtime,
                                 exp_w.op, exp_w.addr, exp_w.len, exp_w.boff, exp_w.scratch,
                                 exp_w.done, exp_w.spare_kb, exp_w.is_last,
                                 got_w.op, got_w.addr, got_w.len, got_w.boff, got_w.scratch,
                                 got_w.done, got_w.spare_kb, got_w.is_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        cmd_t c;
        int unsigned n;
        int unsigned disp;
        flash_word_t w;
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_INIT;
        req_ch.byte_count   = '0;
        req_ch.displacement = '0;
        rsp_ch.ready        = 1'b0;
        rst_n               = 1'b0;

        script.push_back(row(CMD_PULL, 0,      0,      1'b1, 0,      8192));
        script.push_back(row(CMD_DROP, 1,      0,      1'b1, 0,      8192));
        script.push_back(row(CMD_PULL, 1,      0,      1'b1, 0,      8192));
        script.push_back(row(CMD_PUSH, 65535,  0,      1'b1, 65535,  8129));
        script.push_back(row(CMD_PULL, 65535,  0,      1'b1, 65535,  8129));
        script.push_back(row(CMD_PULL, 1,      65535,  1'b1, 0,      8129));
        script.push_back(row(CMD_PULL, 0,      65535,  1'b0, 0,      0));
        script.push_back(row(CMD_PULL, 100,    4000,   1'b0, 0,      0));
        script.push_back(row(CMD_DROP, 0,      0,      1'b0, 0,      0));
        script.push_back(row(CMD_DROP, 4095,   0,      1'b0, 0,      0));
        script.push_back(row(CMD_DROP, 65535,  0,      1'b1, 0,      8132));
        script.push_back(row(CMD_PUSH, 1,      0,      1'b0, 0,      0));
        script.push_back(row(CMD_PUSH, 4095,   0,      1'b0, 0,      0));
        script.push_back(row(CMD_DROP, 0,      0,      1'b0, 0,      0));
        script.push_back(row(CMD_PUSH, 4096,   0,      1'b0, 0,      0));
        script.push_back(row(CMD_INIT, 0,      0,      1'b1, 0,      8192));
        script.push_back(row(CMD_PUSH, 0,      0,      1'b1, 0,      8192));
        script.push_back(row(CMD_DROP, 0,      0,      1'b1, 0,      8192));
        script.push_back(row(CMD_PUSH, 32768,  0,      1'b0, 0,      0));
        script.push_back(row(CMD_PULL, 21845,  43690,  1'b1, 0,      8160));
        script.push_back(row(CMD_DROP, 32768,  0,      1'b1, 32768,  8192));
        script.push_back(row(CMD_PULL, 43690,  21845,  1'b1, 0,      8192));
        script.push_back(row(CMD_INIT, 65535,  65535,  1'b1, 0,      8192));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            offer_command(script[i].cmd, script[i].count, script[i].disp);
            if (script[i].pinned)
            begin
                w = due_words.pop_back();
                w.done     = script[i].pin_done;
                w.spare_kb = script[i].pin_spare;
                due_words.push_back(w);
            end
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case (i / 100)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 51;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 51;
                end
                default:
                begin
                    idle_pct  = 14;
                    stall_pct = 14;
                end
            endcase
            if (i == 100)
                hold_requests++;
            pick_command(c, n, disp);
            offer_command(c, n, disp);
        end
        req_ch.valid <= 1'b0;

        while (due_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/fssm_pkg.sv
design/fssm_req_if.sv
design/fssm_rsp_if.sv
design/fssm_datapath.sv
design/fssm_ctrl.sv
design/flash_sector_stack_manager.sv
design/fssm_checker.sv
verif/tb_flash_sector_stack_manager.sv
